FILE: hdl/assert_macros.svh
// assertion macros shared by the radix parser rtl
// no dependencies; included by the files that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check on a clock, disabled while rst is high
`define RSTI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RSTI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rsti_pkg.sv
// types and constants of the radix string-to-integer parser
// no dependencies; imported by every module of the block
package rsti_pkg;

   localparam int TEXT_WIDTH      = 8;
   localparam int DIGIT_WIDTH     = 6;
   localparam int VALUE_WIDTH     = 64;
   localparam int NARROW_WIDTH    = 32;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;

   // register map
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RADIX  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NARROW = 4'd1;

   localparam logic [DIGIT_WIDTH-1:0] RADIX_RESET = 6'd10;

   // ascii codes
   localparam logic [TEXT_WIDTH-1:0] CHAR_0     = 8'h30;
   localparam logic [TEXT_WIDTH-1:0] CHAR_9     = 8'h39;
   localparam logic [TEXT_WIDTH-1:0] CHAR_LA    = 8'h61;
   localparam logic [TEXT_WIDTH-1:0] CHAR_LZ    = 8'h7a;
   localparam logic [TEXT_WIDTH-1:0] CHAR_UA    = 8'h41;
   localparam logic [TEXT_WIDTH-1:0] CHAR_UZ    = 8'h5a;
   localparam logic [TEXT_WIDTH-1:0] CHAR_UNDER = 8'h5f;
   localparam logic [TEXT_WIDTH-1:0] CHAR_COLON = 8'h3a;
   localparam logic [TEXT_WIDTH-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [TEXT_WIDTH-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [TEXT_WIDTH-1:0] CHAR_SPACE = 8'h20;

   // digit offsets for lower and upper case letters
   localparam logic [DIGIT_WIDTH-1:0] LOWER_BASE = 6'd10;
   localparam logic [DIGIT_WIDTH-1:0] UPPER_BASE = 6'd36;

   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_SKIP,
      KIND_SPACE,
      KIND_PLUS,
      KIND_MINUS,
      KIND_END
   } char_kind_type;

   typedef struct packed {
      char_kind_type          kind;
      logic [DIGIT_WIDTH-1:0] digit;
   } char_class_type;

endpackage

FILE: hdl/rsti_classify.sv
// byte decoder: sorts a text byte into digit, separator, sign, space or end
// depends on rsti_pkg
module rsti_classify (
   input  logic [rsti_pkg::TEXT_WIDTH-1:0] text_byte,
   output rsti_pkg::char_class_type        char_class
);
   import rsti_pkg::*;

   logic [TEXT_WIDTH-1:0] offset;

   always_comb begin
      offset           = '0;
      char_class.kind  = KIND_END;
      char_class.digit = '0;
      if (text_byte inside {[CHAR_0:CHAR_9]}) begin
         offset           = text_byte - CHAR_0;
         char_class.kind  = KIND_DIGIT;
         char_class.digit = offset[DIGIT_WIDTH-1:0];
      end else if (text_byte inside {[CHAR_LA:CHAR_LZ]}) begin
         offset           = text_byte - CHAR_LA;
         char_class.kind  = KIND_DIGIT;
         char_class.digit = offset[DIGIT_WIDTH-1:0] + LOWER_BASE;
      end else if (text_byte inside {[CHAR_UA:CHAR_UZ]}) begin
         offset           = text_byte - CHAR_UA;
         char_class.kind  = KIND_DIGIT;
         char_class.digit = offset[DIGIT_WIDTH-1:0] + UPPER_BASE;
      end else if (text_byte inside {CHAR_UNDER, CHAR_COLON}) begin
         char_class.kind = KIND_SKIP;
      end else if (text_byte == CHAR_SPACE) begin
         char_class.kind = KIND_SPACE;
      end else if (text_byte == CHAR_PLUS) begin
         char_class.kind = KIND_PLUS;
      end else if (text_byte == CHAR_MINUS) begin
         char_class.kind = KIND_MINUS;
      end
   end

endmodule

FILE: hdl/rsti_accum.sv
// parse state and multiply-add datapath: phase, sign and running total
// depends on rsti_pkg and assert_macros.svh
`include "assert_macros.svh"

module rsti_accum (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  rsti_pkg::char_class_type               char_class,
   input  logic [rsti_pkg::DIGIT_WIDTH-1:0]       radix,
   input  logic                                   narrow_result,
   output logic                                   emit,
   output logic signed [rsti_pkg::VALUE_WIDTH-1:0] value
);
   import rsti_pkg::*;

   logic                   in_digits_ff, in_digits_in;
   logic                   negative_ff, negative_in;
   logic [VALUE_WIDTH-1:0] total_ff, total_in;
   logic [VALUE_WIDTH-1:0] scaled;
   logic [VALUE_WIDTH-1:0] signed_total;
   logic                   leading;

   // one 64x6 multiply-add per byte
   assign scaled = total_ff * {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, radix}
                   + {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, char_class.digit};

   assign signed_total = negative_ff ? (VALUE_WIDTH'(0) - total_ff) : total_ff;

   always_comb begin
      value = signed_total;
      if (narrow_result) begin
         value = {{(VALUE_WIDTH-NARROW_WIDTH){signed_total[NARROW_WIDTH-1]}},
                  signed_total[NARROW_WIDTH-1:0]};
      end
   end

   // start phase handles space and sign itself, everything else falls through
   assign leading = !in_digits_ff &&
                    (char_class.kind == KIND_SPACE || char_class.kind == KIND_PLUS ||
                     char_class.kind == KIND_MINUS);

   always_comb begin
      in_digits_in = in_digits_ff;
      negative_in  = negative_ff;
      total_in     = total_ff;
      emit         = 1'b0;
      if (leading) begin
         case (char_class.kind)
            KIND_PLUS: begin
               in_digits_in = 1'b1;
            end
            KIND_MINUS: begin
               in_digits_in = 1'b1;
               negative_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end else begin
         case (char_class.kind)
            KIND_DIGIT: begin
               in_digits_in = 1'b1;
               total_in     = scaled;
            end
            KIND_SKIP: begin
               in_digits_in = 1'b1;
            end
            default: begin
               emit         = 1'b1;
               in_digits_in = 1'b0;
               negative_in  = 1'b0;
               total_in     = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_digits_ff <= 1'b0;
         negative_ff  <= 1'b0;
         total_ff     <= '0;
      end else if (step) begin
         in_digits_ff <= in_digits_in;
         negative_ff  <= negative_in;
         total_ff     <= total_in;
      end
   end

   `RSTI_ASSERT_NEXT(a_emit_restarts, clock, reset, step && emit,
      !in_digits_ff && !negative_ff && total_ff == '0, "state not cleared after a number")
   `RSTI_ASSERT(a_sign_in_digits, clock, reset, !negative_ff || in_digits_ff,
      "sign noted outside the digit phase")
   `RSTI_ASSERT(a_idle_total_zero, clock, reset, in_digits_ff || total_ff == '0,
      "running total nonzero in the start phase")

endmodule

FILE: hdl/radix_string_to_integer.sv
// top level of the radix string-to-integer parser: handshakes, registers, csr
// depends on rsti_pkg, rsti_classify, rsti_accum and assert_macros.svh
`include "assert_macros.svh"

// Parses signed integers out of a stream of text bytes, one byte per word on
// the req channel. Leading spaces are skipped, an optional '+' or '-' sets the
// sign, then digits are accumulated in the radix held in csr register 0
// ('0'-'9' = 0-9, 'a'-'z' = 10-35, 'A'-'Z' = 36-61; '_' and ':' are ignored,
// digits above the radix are accepted as is). Any other byte closes the number
// and sends one word on the rsp channel: the total modulo 2^64, negated for
// '-', and sign-extended from 32 bits when csr register 1 is set. A closing
// byte in the start phase sends 0. The block takes one byte every cycle while
// the rsp side keeps up; a result word held by rsp_stall keeps the buffered
// byte in place and raises req_stall until the word is taken. A closing byte
// passes the input register, then the result register, before its result
// word is valid. The rate is set by the feedback of the running total
// through one 64 by 6 multiply-add per byte. csr writes are always ready and
// are meant for an idle block.
module radix_string_to_integer (
   input  logic                                    clock,
   input  logic                                    reset,
   // text bytes in
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [rsti_pkg::TEXT_WIDTH-1:0]         req_text_byte,
   // parsed values out
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rsti_pkg::VALUE_WIDTH-1:0] rsp_parsed_value,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [rsti_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [rsti_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import rsti_pkg::*;

   // configuration registers
   logic [DIGIT_WIDTH-1:0] radix_ff;
   logic                   narrow_ff;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [TEXT_WIDTH-1:0] in_byte_ff;

   // result register
   logic                          out_valid_ff, out_valid_in;
   logic signed [VALUE_WIDTH-1:0] out_value_ff;

   char_class_type                char_class;
   logic                          emit;
   logic signed [VALUE_WIDTH-1:0] value;
   logic                          out_free;
   logic                          proc_go;
   logic                          req_accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         narrow_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RADIX:  radix_ff  <= csr_wdata[DIGIT_WIDTH-1:0];
            REG_NARROW: narrow_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // result register free when empty or being taken this cycle
   assign out_free   = !out_valid_ff || !rsp_stall;
   // the buffered byte moves on only when its result has somewhere to go
   assign proc_go    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_text_byte;
      end
   end

   rsti_classify u_classify (
      .text_byte  (in_byte_ff),
      .char_class (char_class)
   );

   rsti_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .step          (proc_go),
      .char_class    (char_class),
      .radix         (radix_ff),
      .narrow_result (narrow_ff),
      .emit          (emit),
      .value         (value)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (proc_go) begin
         out_valid_in = emit;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go && emit) begin
         out_value_ff <= value;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_parsed_value = out_value_ff;

   `RSTI_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset,
      !out_valid_ff && !in_valid_ff, "pipeline not empty after reset")
   `RSTI_ASSERT_NEXT(a_emit_lands, clock, reset, proc_go && emit,
      out_valid_ff, "closing byte produced no word")
   `RSTI_ASSERT_NEXT(a_byte_held, clock, reset, in_valid_ff && !out_free,
      in_valid_ff, "buffered byte dropped while blocked")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of radix_string_to_integer: scoreboard class plus drivers
// depends on rsti_pkg and the radix_string_to_integer rtl
import rsti_pkg::*;

// how one text byte is treated once the digit phase has begun
function automatic char_class_type classify_char(logic [TEXT_WIDTH-1:0] b);
   char_class_type c;
   c.digit = '0;
   if (b >= CHAR_0 && b <= CHAR_9) begin
      c.kind  = KIND_DIGIT;
      c.digit = DIGIT_WIDTH'(b - CHAR_0);
   end else if (b >= CHAR_LA && b <= CHAR_LZ) begin
      c.kind  = KIND_DIGIT;
      c.digit = DIGIT_WIDTH'(b - CHAR_LA) + LOWER_BASE;
   end else if (b >= CHAR_UA && b <= CHAR_UZ) begin
      c.kind  = KIND_DIGIT;
      c.digit = DIGIT_WIDTH'(b - CHAR_UA) + UPPER_BASE;
   end else if (b == CHAR_UNDER || b == CHAR_COLON) begin
      c.kind = KIND_SKIP;
   end else if (b == CHAR_SPACE) begin
      c.kind = KIND_SPACE;
   end else if (b == CHAR_PLUS) begin
      c.kind = KIND_PLUS;
   end else if (b == CHAR_MINUS) begin
      c.kind = KIND_MINUS;
   end else begin
      c.kind = KIND_END;
   end
   return c;
endfunction

// predicts the parsed values and checks them in order
class parse_scoreboard;
   logic [DIGIT_WIDTH-1:0] radix;
   logic                   narrow;
   logic                   in_digits;
   logic                   negative;
   logic [VALUE_WIDTH-1:0] total;
   logic [VALUE_WIDTH-1:0] expected_values[$];
   int                     errors;

   function new();
      radix     = RADIX_RESET;
      narrow    = 1'b0;
      in_digits = 1'b0;
      negative  = 1'b0;
      total     = '0;
      errors    = 0;
   endfunction

   function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      if (idx == REG_RADIX) begin
         radix = data[DIGIT_WIDTH-1:0];
      end else if (idx == REG_NARROW) begin
         narrow = data[0];
      end
   endfunction

   function void note_byte(logic [TEXT_WIDTH-1:0] b);
      char_class_type         c;
      logic [VALUE_WIDTH-1:0] v;
      c = classify_char(b);
      if (!in_digits) begin
         if (c.kind == KIND_SPACE) return;
         in_digits = 1'b1;
         if (c.kind == KIND_MINUS) begin
            negative = 1'b1;
            return;
         end
         if (c.kind == KIND_PLUS) return;
      end
      case (c.kind)
         KIND_DIGIT: begin
            total = total * {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, radix}
                  + {{(VALUE_WIDTH-DIGIT_WIDTH){1'b0}}, c.digit};
         end
         KIND_SKIP: begin
         end
         default: begin
            v = negative ? -total : total;
            if (narrow) v = {{(VALUE_WIDTH-NARROW_WIDTH){v[NARROW_WIDTH-1]}},
                             v[NARROW_WIDTH-1:0]};
            expected_values.push_back(v);
            in_digits = 1'b0;
            negative  = 1'b0;
            total     = '0;
         end
      endcase
   endfunction

   function void check_value(logic [VALUE_WIDTH-1:0] v);
      logic [VALUE_WIDTH-1:0] want;
      if (expected_values.size() == 0) begin
         errors++;
         $display("%0t: unexpected parsed value, expected none actual %h", $time, v);
         return;
      end
      want = expected_values.pop_front();
      if (v !== want) begin
         errors++;
         $display("%0t: parsed value mismatch, expected %h actual %h", $time, want, v);
      end
   endfunction
endclass

module tb;

   // radix and narrow setting of each phase; -1 picks a random legal radix / mode
   localparam int NUM_PHASES  = 10;
   localparam int RADIX_PLAN[NUM_PHASES]  = '{10, 62, 3, 63, 16, 0, 36, 1, -1, -1};
   localparam int NARROW_PLAN[NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1, -1, -1};
   localparam int PHASE_BYTES = 150;
   // index that maps to no register, written once to see it change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 4'hf;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [TEXT_WIDTH-1:0]            req_text_byte = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic signed [VALUE_WIDTH-1:0]    rsp_parsed_value;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]       csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]        csr_wdata = '0;

   parse_scoreboard sb;

   // sender burst bookkeeping and byte count
   int burst_left = 0;
   int bytes_sent = 0;

   // receiver stall pattern state
   int   stall_mode   = 0;
   int   stall_cycles = 0;
   int   stall_run    = 0;
   logic stall_on     = 1'b0;

   radix_string_to_integer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // watch all three channels at the edge; values seen here are the pre-edge ones
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) sb.note_byte(req_text_byte);
         if (rsp_valid && !rsp_stall) sb.check_value(rsp_parsed_value);
      end
   end

   // receiver stall: switch between three modes, no stall,
   // randomly scattered stalls and on/off runs of random length
   always @(posedge clock) begin
      if (stall_cycles == 0) begin
         stall_mode   = $urandom_range(0, 2);
         stall_cycles = $urandom_range(50, 300);
      end
      stall_cycles--;
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            if (stall_run == 0) begin
               stall_run = $urandom_range(1, 8);
               stall_on  = ~stall_on;
            end
            stall_run--;
            rsp_stall <= stall_on;
         end
      endcase
   end

   // one word on the req channel; a new burst may open with a gap of idle cycles
   task automatic send_byte(logic [TEXT_WIDTH-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // stop sending until every predicted value is out, then let the pipe settle
   task automatic wait_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.expected_values.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // csr word; valid stays high so back-to-back writes need one assignment per edge
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   function automatic logic [TEXT_WIDTH-1:0] digit_char(int d);
      if (d < 10) return TEXT_WIDTH'(CHAR_0 + d);
      if (d < 36) return TEXT_WIDTH'(CHAR_LA + d - 10);
      return TEXT_WIDTH'(CHAR_UA + d - 36);
   endfunction

   // well-formed number: spaces, optional sign, digits with separators, terminator
   task automatic send_number(int radix_now);
      int                    spaces;
      int                    n;
      int                    top;
      logic [TEXT_WIDTH-1:0] b;
      char_class_type        c;
      spaces = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (spaces) send_byte(CHAR_SPACE);
      case ($urandom_range(0, 2))
         0: send_byte(CHAR_PLUS);
         1: send_byte(CHAR_MINUS);
         default: begin
         end
      endcase
      // mostly short numbers, some long enough to wrap the total
      n   = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 28) : $urandom_range(0, 6);
      top = (radix_now > 62) ? 62 : radix_now;
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte($urandom_range(0, 1) ? CHAR_UNDER : CHAR_COLON);
         end else if (top >= 1 && $urandom_range(0, 9) != 0) begin
            send_byte(digit_char($urandom_range(0, top - 1)));
         end else begin
            // any digit, possibly at or above the radix, which is still accumulated
            send_byte(digit_char($urandom_range(0, 61)));
         end
      end
      do begin
         b = TEXT_WIDTH'($urandom_range(0, 255));
         c = classify_char(b);
      end while (c.kind == KIND_DIGIT || c.kind == KIND_SKIP);
      send_byte(b);
   endtask

   initial begin
      int radix_now;
      int narrow_now;
      int target;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset setting (radix 10, full width)
      send_text("  +9_9:0,");     // leading spaces, plus sign, both separators
      send_text("-z.");           // minus sign, digit above the radix
      send_text("Z");             // top upper case digit
      send_byte(8'hff);           // terminator with every bit set
      send_text("!");             // terminator in the start phase gives 0
      send_text("_,");            // separator in the start phase is ignored
      send_text("--");            // second minus ends the number
      send_text("A0 ");           // space after digits ends the number
      send_text("9");
      send_byte(8'h00);           // all-zero terminator

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         radix_now  = (RADIX_PLAN[phase] < 0) ? $urandom_range(3, 62) : RADIX_PLAN[phase];
         narrow_now = (NARROW_PLAN[phase] < 0) ? $urandom_range(0, 1) : NARROW_PLAN[phase];
         // upper data bits are random; only the low register bits count
         write_csr(REG_RADIX, {2'($urandom_range(0, 3)), DIGIT_WIDTH'(radix_now)});
         write_csr(REG_NARROW, {7'($urandom_range(0, 127)), 1'(narrow_now)});
         if (phase == 0) write_csr(REG_UNUSED, CSR_DATA_WIDTH'($urandom_range(0, 255)));
         csr_valid <= 1'b0;
         @(posedge clock);

         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if ($urandom_range(0, 199) == 0) wait_drained();
            if ($urandom_range(0, 19) < 17) begin
               send_number(radix_now);
            end else begin
               // noise: arbitrary bytes, breaking sequences up
               repeat ($urandom_range(1, 4)) send_byte(TEXT_WIDTH'($urandom_range(0, 255)));
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit far above the slowest correct run
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
